FILE: rtl/core/button_edge_debounce_queue_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the button edge debounce queue
// Shared same-cycle and next-cycle implication checks on the block's clock.
// ---------------------------------------------------------------------------
`ifndef BUTTON_EDGE_DEBOUNCE_QUEUE_TOP_ASSERT_SVH
`define BUTTON_EDGE_DEBOUNCE_QUEUE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BEDQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BEDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/bedq_pkg.sv
// ---------------------------------------------------------------------------
// Button edge debounce queue package
// Constants and the event word type for the debounce queue.
// ---------------------------------------------------------------------------
`default_nettype none

package bedq_pkg;

  // Default ring depth; the ring holds one event fewer than its depth.
  localparam int unsigned QueueDepthDefault = 8;

  // Lockout time after reset, in milliseconds.
  localparam logic [15:0] DebounceReset = 16'd25;

  // Configuration address width and register index.
  localparam int unsigned AddrW      = 3;
  localparam logic        RegDebounce = 1'b0;

  // Request kinds carried by req_type.
  localparam logic ReqEdge = 1'b0;
  localparam logic ReqPoll = 1'b1;

  // One queued edge: the level and its time stamp.
  typedef struct packed {
    logic        level;
    logic [31:0] stamp;
  } evt_t;

endpackage

`default_nettype wire

FILE: rtl/core/button_edge_debounce_queue_top.sv
// Edge word: accepted while idle; it never produces a result word.
// Poll word: each queued event takes a ring read and a check, then the poll
// reconciles and flushes; the single 32-bit subtract-compare and the registered
// ring read set these steps. Stalls on the output can hold the later steps.
// Reset clears control state and sets the lockout to 25 ms; the event ring
// contents are not cleared.
`default_nettype none

// ---------------------------------------------------------------------------
// Button edge debounce queue
// Edge-lockout debouncer for one button with an event ring drained by polls.
// ---------------------------------------------------------------------------
module button_edge_debounce_queue_top #(
  parameter int unsigned QUEUE_DEPTH = bedq_pkg::QueueDepthDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // Configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [bedq_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  // Input channel
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       req_type_i,
  input  wire logic                       level_down_i,
  input  wire logic [31:0]                now_ms_i,
  // Output channel
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            pressed_o,
  output logic      [31:0]                event_ms_o,
  output logic                            last_of_run_o
);

  import bedq_pkg::*;

  localparam int unsigned SlotW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(QUEUE_DEPTH - 1);

  // Sequencer states.
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRead  = 3'd1;
  localparam logic [2:0] StCheck = 3'd2;
  localparam logic [2:0] StRecon = 3'd3;
  localparam logic [2:0] StFlush = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [15:0]      deb_q;
  logic [31:0]      last_q, last_d;
  logic [31:0]      now_q;
  logic             raw_q, raw_d;
  logic             rep_q, rep_d;
  logic [SlotW-1:0] wr_q, wr_d;
  logic [SlotW-1:0] rd_q, rd_d;
  evt_t             store_q [QUEUE_DEPTH];
  evt_t             rd_data_q;
  logic             store_we;
  evt_t             pend_q, pend_d;
  logic             pend_valid_q, pend_valid_d;
  logic             out_valid_q;
  logic             out_pressed_q, out_last_q;
  logic [31:0]      out_ms_q;
  logic             push, push_last, can_push;
  logic             in_acc;
  logic [31:0]      cmp_now, elapsed;
  logic             lock_done;
  logic             new_rep;
  logic             cfg_wr;

  function automatic logic [SlotW-1:0] next_slot(input logic [SlotW-1:0] s);
    next_slot = (s == LastSlot) ? '0 : s + SlotW'(1);
  endfunction

  // Configuration access: one register, always ready.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == RegDebounce) ? {16'd0, deb_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q <= DebounceReset;
    end else if (cfg_wr && paddr[2] == RegDebounce) begin
      deb_q <= pwdata[15:0];
    end
  end

  // Shared subtract-compare: has the lockout expired at this time?
  assign cmp_now   = (state_q == StIdle) ? now_ms_i : now_q;
  assign elapsed   = cmp_now - last_q;
  assign lock_done = elapsed >= {16'd0, deb_q};

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i & in_ready_o;
  assign can_push   = !out_valid_q || out_ready_i;

  // Sequencer and state update.
  always_comb begin
    state_d      = state_q;
    last_d       = last_q;
    raw_d        = raw_q;
    rep_d        = rep_q;
    wr_d         = wr_q;
    rd_d         = rd_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    store_we     = 1'b0;
    push         = 1'b0;
    push_last    = 1'b0;
    new_rep      = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_acc && req_type_i == ReqEdge) begin
          raw_d = level_down_i;
          if (lock_done) begin
            last_d = now_ms_i;
            if (next_slot(wr_q) != rd_q) begin
              store_we = 1'b1;
              wr_d     = next_slot(wr_q);
            end
          end
        end else if (in_acc) begin
          state_d = (rd_q == wr_q) ? StRecon : StRead;
        end
      end
      StRead: begin
        rd_d    = next_slot(rd_q);
        state_d = StCheck;
      end
      StCheck: begin
        new_rep = rd_data_q.level != rep_q;
        if (!(new_rep && pend_valid_q && !can_push)) begin
          push = new_rep && pend_valid_q;
          if (new_rep) begin
            pend_d       = rd_data_q;
            pend_valid_d = 1'b1;
            rep_d        = rd_data_q.level;
          end
          state_d = (rd_q == wr_q) ? StRecon : StRead;
        end
      end
      StRecon: begin
        new_rep = (rep_q != raw_q) && lock_done;
        if (!(new_rep && pend_valid_q && !can_push)) begin
          push = new_rep && pend_valid_q;
          if (new_rep) begin
            pend_d       = '{level: raw_q, stamp: now_q};
            pend_valid_d = 1'b1;
            rep_d        = raw_q;
          end
          state_d = StFlush;
        end
      end
      StFlush: begin
        if (!pend_valid_q) begin
          state_d = StIdle;
        end else if (can_push) begin
          push         = 1'b1;
          push_last    = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      last_q       <= '0;
      raw_q        <= 1'b0;
      rep_q        <= 1'b0;
      wr_q         <= '0;
      rd_q         <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      last_q       <= last_d;
      raw_q        <= raw_d;
      rep_q        <= rep_d;
      wr_q         <= wr_d;
      rd_q         <= rd_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // Payload registers: poll time and the held-back result.
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (in_acc) begin
      now_q <= now_ms_i;
    end
  end

  // Event ring with registered read.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[wr_q] <= '{level: level_down_i, stamp: now_ms_i};
    end
    if (state_q == StRead) begin
      rd_data_q <= store_q[rd_q];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_pressed_q <= pend_q.level;
      out_ms_q      <= pend_q.stamp;
      out_last_q    <= push_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pressed_o     = out_pressed_q;
  assign event_ms_o    = out_ms_q;
  assign last_of_run_o = out_last_q;

  // Design checks.
`include "button_edge_debounce_queue_top_assert.svh"

  `BEDQ_ASSERT_SAME(a_idle_no_pending, state_q == StIdle, !pend_valid_q,
                    "pending result left over in idle")
  `BEDQ_ASSERT_SAME(a_flush_ring_empty, state_q == StFlush, rd_q == wr_q,
                    "poll finished with events still queued")
  `BEDQ_ASSERT_NEXT(a_last_clears_pending, push && push_last, !pend_valid_q,
                    "pending result kept after the final word")
  `BEDQ_ASSERT_SAME(a_push_has_room, push, can_push,
                    "result pushed over an untaken word")

endmodule

`default_nettype wire
